// ===== rtl/aapg_pkg.sv =====
// Package for the alarm annunciator pattern generator.
// Holds the policy and buzzer stage codes, the item and result types and the policy table.
// No dependencies.
package aapg_pkg;

   localparam logic [2:0] POL_SAFE      = 3'd0;
   localparam logic [2:0] POL_WARNING   = 3'd1;
   localparam logic [2:0] POL_DANGER    = 3'd2;
   localparam logic [2:0] POL_HARDFAULT = 3'd3;
   localparam logic [2:0] POL_LOST      = 3'd4;

   localparam logic [2:0] LEVEL_HARDFAULT = 3'd3;

   localparam logic [1:0] STAGE_SOUND = 2'd0;
   localparam logic [1:0] STAGE_INTER = 2'd1;
   localparam logic [1:0] STAGE_GAP   = 2'd2;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_STATUS = 1'b1;

   typedef struct packed {
      logic       op;
      logic [2:0] alert_grade;
      logic       heartbeat_stale;
   } item_type;

   typedef struct packed {
      logic [2:0]  policy_in_force;
      logic [11:0] buzzer_freq_hz;
      logic        led_blue;
      logic        led_green;
      logic        led_red;
   } result_type;

   typedef struct packed {
      logic        red;
      logic        green;
      logic        blue;
      logic        blink;
      logic [11:0] freq;
      logic        sequenced;
      logic [1:0]  beats;
   } plan_type;

   function automatic plan_type plan_of(input logic [2:0] pol);
      plan_type p;
      p = '0;
      case (pol)
         POL_SAFE: begin
            p.green = 1'b1;
         end
         POL_WARNING: begin
            p.red = 1'b1; p.green = 1'b1; p.blink = 1'b1;
            p.freq = 12'd3000; p.sequenced = 1'b1; p.beats = 2'd1;
         end
         POL_DANGER: begin
            p.red = 1'b1; p.blink = 1'b1;
            p.freq = 12'd3000; p.sequenced = 1'b1; p.beats = 2'd2;
         end
         POL_HARDFAULT: begin
            p.red = 1'b1; p.blink = 1'b1;
            p.freq = 12'd4000; p.sequenced = 1'b1; p.beats = 2'd0;
         end
         POL_LOST: begin
            p.blue = 1'b1; p.freq = 12'd4000;
         end
         default: begin
            p.green = 1'b1;
         end
      endcase
      return p;
   endfunction

   // Milliseconds to ticks, never less than one tick. Used at elaboration only.
   function automatic int ms_to_ticks(input int tps, input int ms);
      int t;
      t = (tps * ms) / 1000;
      return (t < 1) ? 1 : t;
   endfunction

endpackage

// ===== rtl/alarm_annunciator_pattern_generator_unit.sv =====
// Top level of the alarm annunciator pattern generator.
// Input register, result register and stream handshake around the policy core.
// Depends on aapg_pkg and aapg_core.

// The block takes one transaction per clock cycle on the request stream: either a
// timer tick (req_tuser = 0) or a new alarm status (req_tuser = 1, with the alarm
// level and supervisor-lost flag in req_tdata). Each request yields exactly one
// response transaction carrying the RGB LED levels, the buzzer frequency in hertz
// and the policy in force after the request was applied. A request first lands in
// an input register; the policy state and its response are then computed in a single
// pass and the response is held in the result register, which raises rsp_tvalid. The
// input register keeps accepting while it is empty, so the request side stalls only
// while both registers are full and the response waits to be taken; with rsp_tready
// held high one transaction moves through every cycle. Supervisor loss outranks the
// alarm level, and alarm levels above hardfault are treated as safe. A status that
// selects the policy already in force changes nothing; a new policy restarts the
// blink phase and the buzzer sequencer. All blink and beep periods are counted in
// ticks derived from TICKS_PER_SECOND, each at least one tick. After reset the safe
// policy is in force.
module alarm_annunciator_pattern_generator_unit import aapg_pkg::*; #(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] alert_grade, [3] heartbeat_stale, zero fill above
   input  logic [0:0]  req_tuser,   // [0] op: 0 timer tick, 1 alarm status

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] led_red, [1] led_green, [2] led_blue,
                                    // [14:3] buzzer_freq_hz, [17:15] policy_in_force
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   logic       advance;
   logic       fire;
   result_type result;

   // The pipeline moves whenever the result register is empty or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.op              <= req_tuser[0];
         in_item_ff.alert_grade     <= req_tdata[2:0];
         in_item_ff.heartbeat_stale <= req_tdata[3];
      end
   end

   aapg_core #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

// ===== rtl/aapg_core.sv =====
// Policy state and pattern sequencer of the alarm annunciator pattern generator.
// Applies one item per fire and presents the result computed from the updated state.
// Depends on aapg_pkg.
module aapg_core import aapg_pkg::*; #(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   localparam int CD_W = $clog2(2 * TICKS_PER_SECOND + 1);

   localparam logic [CD_W-1:0] T_2000 = CD_W'(ms_to_ticks(TICKS_PER_SECOND, 2000));
   localparam logic [CD_W-1:0] T_1000 = CD_W'(ms_to_ticks(TICKS_PER_SECOND, 1000));
   localparam logic [CD_W-1:0] T_500  = CD_W'(ms_to_ticks(TICKS_PER_SECOND, 500));
   localparam logic [CD_W-1:0] T_100  = CD_W'(ms_to_ticks(TICKS_PER_SECOND, 100));
   localparam logic [CD_W-1:0] T_50   = CD_W'(ms_to_ticks(TICKS_PER_SECOND, 50));
   localparam logic [CD_W-1:0] T_0    = CD_W'(ms_to_ticks(TICKS_PER_SECOND, 0));
   localparam logic [CD_W-1:0] CD_ONE = CD_W'(1);

   logic [2:0]      policy_ff, policy_in;
   logic            phase_ff, phase_in;
   logic [CD_W-1:0] led_cd_ff, led_cd_in;
   logic [1:0]      stage_ff, stage_in;
   logic [1:0]      beats_ff, beats_in;
   logic [CD_W-1:0] beep_cd_ff, beep_cd_in;

   logic [2:0]      req_policy;
   plan_type        cur_plan, next_plan, out_plan;
   logic [CD_W-1:0] blink_load, on_load, inter_load, gap_load, new_blink_load, new_on_load;
   logic [1:0]      beats_next;
   logic            lit;

   assign cur_plan = plan_of(policy_ff);

   assign req_policy = item.heartbeat_stale ? POL_LOST :
                       (item.alert_grade <= LEVEL_HARDFAULT) ? item.alert_grade : POL_SAFE;
   assign next_plan = plan_of(req_policy);

   always_comb begin
      blink_load = T_100; on_load = T_100; inter_load = T_100; gap_load = T_1000;
      case (policy_ff)
         POL_WARNING: begin
            blink_load = T_500; inter_load = T_0; gap_load = T_2000;
         end
         POL_HARDFAULT: begin
            on_load = T_50; inter_load = T_50;
         end
         default: ;
      endcase
   end

   always_comb begin
      new_blink_load = T_100; new_on_load = T_100;
      case (req_policy)
         POL_WARNING:   new_blink_load = T_500;
         POL_HARDFAULT: new_on_load = T_50;
         default: ;
      endcase
   end

   assign beats_next = beats_ff + 2'd1;

   always_comb begin
      policy_in  = policy_ff;
      phase_in   = phase_ff;
      led_cd_in  = led_cd_ff;
      stage_in   = stage_ff;
      beats_in   = beats_ff;
      beep_cd_in = beep_cd_ff;
      if (fire) begin
         if (item.op == OP_STATUS) begin
            if (req_policy != policy_ff) begin
               policy_in = req_policy;
               if (next_plan.blink) begin
                  phase_in  = 1'b1;
                  led_cd_in = new_blink_load;
               end else begin
                  led_cd_in = '0;
               end
               beats_in   = 2'd0;
               stage_in   = STAGE_SOUND;
               beep_cd_in = next_plan.sequenced ? new_on_load : '0;
            end
         end else begin
            if (cur_plan.blink) begin
               if (led_cd_ff <= CD_ONE) begin
                  phase_in  = ~phase_ff;
                  led_cd_in = blink_load;
               end else begin
                  led_cd_in = led_cd_ff - CD_ONE;
               end
            end
            if (cur_plan.sequenced) begin
               if (beep_cd_ff <= CD_ONE) begin
                  if (stage_ff == STAGE_SOUND) begin
                     if (cur_plan.beats != 2'd0 && beats_next >= cur_plan.beats) begin
                        beats_in   = 2'd0;
                        stage_in   = STAGE_GAP;
                        beep_cd_in = gap_load;
                     end else begin
                        beats_in   = beats_next;
                        stage_in   = STAGE_INTER;
                        beep_cd_in = inter_load;
                     end
                  end else begin
                     stage_in   = STAGE_SOUND;
                     beep_cd_in = on_load;
                  end
               end else begin
                  beep_cd_in = beep_cd_ff - CD_ONE;
               end
            end
         end
      end
   end

   // The result reflects the state after this item is applied.
   assign out_plan = plan_of(policy_in);
   assign lit      = !out_plan.blink || phase_in;

   always_comb begin
      result.led_red         = lit & out_plan.red;
      result.led_green       = lit & out_plan.green;
      result.led_blue        = lit & out_plan.blue;
      result.policy_in_force = policy_in;
      if (out_plan.sequenced && stage_in != STAGE_SOUND) begin
         result.buzzer_freq_hz = '0;
      end else begin
         result.buzzer_freq_hz = out_plan.freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_SAFE;
         phase_ff   <= 1'b0;
         led_cd_ff  <= '0;
         stage_ff   <= STAGE_SOUND;
         beats_ff   <= 2'd0;
         beep_cd_ff <= '0;
      end else begin
         policy_ff  <= policy_in;
         phase_ff   <= phase_in;
         led_cd_ff  <= led_cd_in;
         stage_ff   <= stage_in;
         beats_ff   <= beats_in;
         beep_cd_ff <= beep_cd_in;
      end
   end

   // A blinking policy always has a pending toggle.
   a_blink_cd_live: assert property (@(posedge clock) disable iff (reset)
      cur_plan.blink |-> led_cd_ff != '0)
      else $error("blink countdown empty under blinking policy");

   // The buzzer sequencer never enters the unused stage.
   a_stage_legal: assert property (@(posedge clock) disable iff (reset)
      stage_ff != 2'd3)
      else $error("buzzer stage holds unused code");

   // A status item naming the policy in force leaves every state register alone.
   a_same_policy_hold: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == OP_STATUS && req_policy == policy_ff |=>
         $stable(phase_ff) && $stable(led_cd_ff) && $stable(stage_ff) &&
         $stable(beats_ff) && $stable(beep_cd_ff))
      else $error("state changed on an unchanged policy");

   // Without a sequencer the buzzer stage rests at sounding.
   a_idle_stage: assert property (@(posedge clock) disable iff (reset)
      !cur_plan.sequenced |-> stage_ff == STAGE_SOUND)
      else $error("buzzer stage moved under a non-sequenced policy");

endmodule
